/* src/thermo_pkg.sv */
package thermo_pkg;

  localparam int DIVW = 68;
  localparam int RQW = 48;
  localparam int TQW = 13;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [1:0] CFG_SET_TEMP = 2'd0;
  localparam logic [1:0] CFG_COEFF_A = 2'd1;
  localparam logic [1:0] CFG_COEFF_B = 2'd2;
  localparam logic [1:0] CFG_COEFF_C = 2'd3;

  localparam logic signed [12:0] T_MAX = 13'sd4095;
  localparam logic signed [12:0] T_MIN = -13'sd4096;

  typedef struct packed {
    logic load;
    logic div_step;
    logic r_load;
    logic norm_step;
    logic sq_load;
    logic sq_step;
    logic mul_ln;
    logic mul_sq;
    logic mul_cu;
    logic mul_pc;
    logic sum;
    logic t_init;
    logic fin;
  } thermo_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_free;
  } thermo_sts_t;

endpackage

/* src/thermo_ctrl.sv */
module thermo_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  thermo_pkg::thermo_sts_t sts,
  output thermo_pkg::thermo_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDIV  = 13'b0000000000010,
    S_RLOAD = 13'b0000000000100,
    S_NORM  = 13'b0000000001000,
    S_SQ    = 13'b0000000010000,
    S_LN    = 13'b0000000100000,
    S_SQR   = 13'b0000001000000,
    S_CUB   = 13'b0000010000000,
    S_PCM   = 13'b0000100000000,
    S_SUM   = 13'b0001000000000,
    S_TINIT = 13'b0010000000000,
    S_TDIV  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(thermo_pkg::RQW - 1)) begin
          state_nxt = S_RLOAD;
        end
      end
      S_RLOAD: begin
        cmd.r_load = 1'b1;
        state_nxt  = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cmd.sq_load = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 6'd1;
        if (cnt_r == 6'd23) begin
          state_nxt = S_LN;
        end
      end
      S_LN: begin
        cmd.mul_ln = 1'b1;
        state_nxt  = S_SQR;
      end
      S_SQR: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = S_CUB;
      end
      S_CUB: begin
        cmd.mul_cu = 1'b1;
        state_nxt  = S_PCM;
      end
      S_PCM: begin
        cmd.mul_pc = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_TINIT;
      end
      S_TINIT: begin
        cmd.t_init = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_TDIV;
      end
      S_TDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(thermo_pkg::TQW - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_tdiv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TDIV |-> cnt_r < 6'(thermo_pkg::TQW))
    else $error("quotient step count overran");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && sts.out_free |=> state_r == S_IDLE)
    else $error("result not handed over");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_RDIV && cnt_r == 6'd0)
    else $error("divide did not start after load");

endmodule

/* src/thermo_dpath.sv */
module thermo_dpath #(
  parameter int ADC_BITS      = 12,
  parameter int PUBLISH_LIMIT = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  thermo_pkg::thermo_cmd_t cmd,
  output thermo_pkg::thermo_sts_t sts,
  input  logic [11:0]             in_adc_sample,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [12:0]      out_temp_now,
  output logic                    out_heater_on,
  output logic signed [12:0]      out_temp_highest,
  output logic signed [12:0]      out_temp_lowest,
  output logic                    out_publish_now,
  output logic                    out_zero_reading
);

  localparam logic [16:0] FS_FULL = 17'((64'd1 << ADC_BITS) - 64'd1);
  localparam int CW = $clog2(PUBLISH_LIMIT + 2);
  localparam int DW = thermo_pkg::DIVW;

  // configuration
  logic signed [12:0] set_r;
  logic signed [31:0] coef_a_r, coef_b_r, coef_c_r;

  // shared divider
  logic [DW-1:0]  rem_r, dsh_r;
  logic [47:0]    quo_r;
  logic           ovf_r, zero_r, tneg_r;

  // log and polynomial
  logic [47:0]        m48_r;
  logic [5:0]         p_r;
  logic [31:0]        m_r;
  logic [23:0]        frac_r;
  logic [28:0]        l_r;
  logic [33:0]        lsq_r;
  logic [38:0]        l3_r;
  logic signed [37:0] pb_r;
  logic signed [46:0] pch_r;
  logic signed [32:0] pcl_r;
  logic signed [48:0] sum_r;

  // running state
  logic               heat_r;
  logic signed [12:0] max_r, min_r;
  logic [CW-1:0]      pcnt_r;

  // result
  logic               out_valid_r;
  logic signed [12:0] temp_r, omax_r, omin_r;
  logic               oheat_r, opub_r, ozero_r;

  // resistance divide setup
  logic [15:0] s16, smp;
  logic [21:0] rdiff;
  logic [35:0] rprod;
  logic [DW-1:0] rnum, rdsh;
  logic [20:0] rden;
  logic        rovf;

  assign s16   = {4'b0, in_adc_sample};
  assign smp   = (s16 > FS_FULL[15:0]) ? FS_FULL[15:0] : s16;
  assign rdiff = ({6'b0, FS_FULL[15:0]} * 22'd33) - ({6'b0, smp} * 22'd24);
  assign rprod = {14'b0, rdiff} * 36'd10000;
  assign rnum  = {16'b0, rprod, 16'b0};
  assign rden  = {5'b0, smp} * 21'd24;
  assign rdsh  = DW'(rden) << 47;
  assign rovf  = {1'b0, rnum} >= ((DW + 1)'(rden) << 48);

  // temperature divide setup
  logic signed [65:0] tprod;
  logic signed [67:0] tnum, tnadj;
  logic signed [52:0] tden, tdadj;
  logic [67:0]        tmag;
  logic [52:0]        tdabs;
  logic [DW-1:0]      tdsh;
  logic               tovf;

  assign tprod = sum_r * 66'sd43691;
  assign tnum  = 68'sd175921860444160 - 68'(tprod);
  assign tden  = sum_r * 53'sd10;
  assign tnadj = sum_r[48] ? -tnum : tnum;
  assign tdadj = sum_r[48] ? -tden : tden;
  assign tmag  = tnadj[67] ? 68'(-tnadj) : 68'(tnadj);
  assign tdabs = tdadj;
  assign tdsh  = DW'(tdabs) << 12;
  assign tovf  = {1'b0, tmag} >= ((DW + 1)'(tdabs) << 13);

  // divider step
  logic          dge;
  assign dge = rem_r >= dsh_r;

  // log steps
  logic [47:0] rq, rqc;
  logic [63:0] sqp;
  logic [32:0] sq33;
  logic [28:0] l2v;
  logic [60:0] lnp;
  logic [57:0] sqrp;
  logic [62:0] cup;
  logic signed [61:0] pbp;
  logic signed [46:0] pchp;
  logic signed [56:0] pclp;

  assign rq   = ovf_r ? 48'hFFFF_FFFF_FFFF : quo_r;
  assign rqc  = (rq[47:16] == 32'd0) ? 48'h0000_0001_0000 : rq;
  assign sqp  = {32'b0, m_r} * {32'b0, m_r};
  assign sq33 = sqp[63:31];
  assign l2v  = {5'(p_r - 6'd16), frac_r};
  assign lnp  = 61'(l2v) * 61'(thermo_pkg::LN2_Q32);
  assign sqrp = 58'(l_r) * 58'(l_r);
  assign cup  = 63'(lsq_r) * 63'(l_r);
  assign pbp  = coef_b_r * $signed({1'b0, l_r});
  assign pchp = coef_c_r * $signed({1'b0, l3_r[38:24]});
  assign pclp = coef_c_r * $signed({1'b0, l3_r[23:0]});

  // final temperature
  logic signed [14:0] tv, st15, hi15, lo15;
  logic signed [12:0] tsat;
  logic               heat_nxt, pub;
  logic signed [12:0] max_nxt, min_nxt;
  logic [CW-1:0]      pcnt_nxt;

  always_comb begin
    if (tneg_r) begin
      tv = -$signed({2'b0, quo_r[12:0]}) - $signed(15'(rem_r != '0));
    end else begin
      tv = $signed({2'b0, quo_r[12:0]});
    end
    if (sum_r == '0) begin
      tsat = thermo_pkg::T_MAX;
    end else if (ovf_r) begin
      tsat = tneg_r ? thermo_pkg::T_MIN : thermo_pkg::T_MAX;
    end else if (tv > 15'sd4095) begin
      tsat = thermo_pkg::T_MAX;
    end else if (tv < -15'sd4096) begin
      tsat = thermo_pkg::T_MIN;
    end else begin
      tsat = tv[12:0];
    end
    st15 = 15'(set_r);
    hi15 = st15 + 15'sd16;
    lo15 = st15 - 15'sd16;
    heat_nxt = heat_r;
    if (15'(tsat) > hi15) begin
      heat_nxt = 1'b0;
    end else if (15'(tsat) < lo15) begin
      heat_nxt = 1'b1;
    end
    max_nxt = (tsat > max_r) ? tsat : max_r;
    min_nxt = (tsat < min_r) ? tsat : min_r;
    if (pcnt_r > CW'(PUBLISH_LIMIT)) begin
      pub      = 1'b1;
      pcnt_nxt = '0;
    end else begin
      pub      = 1'b0;
      pcnt_nxt = pcnt_r + CW'(1);
    end
  end

  assign sts.norm_done = m48_r[47];
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r    <= 13'sd320;
      coef_a_r <= 32'sd1241510000;
      coef_b_r <= 32'sd257420000;
      coef_c_r <= 32'sd96397;
    end else if (cfg_we) begin
      case (cfg_index)
        thermo_pkg::CFG_SET_TEMP: set_r    <= cfg_data[12:0];
        thermo_pkg::CFG_COEFF_A:  coef_a_r <= cfg_data;
        thermo_pkg::CFG_COEFF_B:  coef_b_r <= cfg_data;
        thermo_pkg::CFG_COEFF_C:  coef_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= rnum;
      dsh_r  <= rdsh;
      quo_r  <= '0;
      ovf_r  <= rovf;
      zero_r <= (smp == 16'd0);
    end else if (cmd.t_init) begin
      rem_r  <= tmag;
      dsh_r  <= tdsh;
      quo_r  <= '0;
      ovf_r  <= tovf;
      tneg_r <= tnadj[67];
    end else if (cmd.div_step) begin
      if (dge) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[46:0], dge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.r_load) begin
      m48_r <= rqc;
      p_r   <= 6'd47;
    end else if (cmd.norm_step) begin
      m48_r <= m48_r << 1;
      p_r   <= p_r - 6'd1;
    end
    if (cmd.sq_load) begin
      m_r    <= m48_r[47:16];
      frac_r <= '0;
    end else if (cmd.sq_step) begin
      m_r    <= sq33[32] ? sq33[32:1] : sq33[31:0];
      frac_r <= {frac_r[22:0], sq33[32]};
    end
    if (cmd.mul_ln) begin
      l_r <= lnp[60:32];
    end
    if (cmd.mul_sq) begin
      lsq_r <= sqrp[57:24];
    end
    if (cmd.mul_cu) begin
      l3_r <= cup[62:24];
      pb_r <= pbp[61:24];
    end
    if (cmd.mul_pc) begin
      pch_r <= pchp;
      pcl_r <= pclp[56:24];
    end
    if (cmd.sum) begin
      sum_r <= 49'(coef_a_r) + 49'(pb_r) + 49'(pch_r) + 49'(pcl_r);
    end
    if (cmd.fin) begin
      temp_r  <= tsat;
      oheat_r <= heat_nxt;
      omax_r  <= max_nxt;
      omin_r  <= min_nxt;
      opub_r  <= pub;
      ozero_r <= zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r      <= 1'b0;
      max_r       <= thermo_pkg::T_MIN;
      min_r       <= thermo_pkg::T_MAX;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        heat_r      <= heat_nxt;
        max_r       <= max_nxt;
        min_r       <= min_nxt;
        pcnt_r      <= pcnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_now     = temp_r;
  assign out_heater_on    = oheat_r;
  assign out_temp_highest = omax_r;
  assign out_temp_lowest  = omin_r;
  assign out_publish_now  = opub_r;
  assign out_zero_reading = ozero_r;

  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> omax_r >= omin_r)
    else $error("running max below running min");

  a_temp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> temp_r <= omax_r && temp_r >= omin_r)
    else $error("temperature outside running extremes");

  a_pub_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && opub_r |-> pcnt_r == '0)
    else $error("publish count not restarted");

endmodule

/* src/thermistor_thermostat.sv */
// Converts one 12-bit converter reading per transaction into a temperature in
// sixteenths of a degree Celsius through the thermistor divider equation and
// the Steinhart-Hart fit, and reports heater state with one degree hysteresis,
// running extremes, a publish pulse every PUBLISH_LIMIT+2 samples and a flag
// for a zero reading. Each sample runs these steps before the next is taken:
// the accept step, a 48-step restoring divide for the resistance, a load step,
// a normalization set by the resistance magnitude, 24 squaring steps of the
// log unit, the log, square, cube and polynomial multiplies, a sum step, a
// divide setup step, a 13-step divide on the same shift-subtract unit for the
// reciprocal and a hand-over step that waits while a stalled result holds the
// output register. A new sample is taken as soon as the previous result sits
// in the output register. The user must write coefficients and set point on
// the cfg port only while no sample is in flight; this is not enforced.
module thermistor_thermostat #(
  parameter int ADC_BITS      = 12,
  parameter int PUBLISH_LIMIT = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_adc_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [12:0] out_temp_now,
  output logic               out_heater_on,
  output logic signed [12:0] out_temp_highest,
  output logic signed [12:0] out_temp_lowest,
  output logic               out_publish_now,
  output logic               out_zero_reading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  thermo_pkg::thermo_cmd_t cmd;
  thermo_pkg::thermo_sts_t sts;

  assign cfg_ready = 1'b1;

  thermo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  thermo_dpath #(
    .ADC_BITS      (ADC_BITS),
    .PUBLISH_LIMIT (PUBLISH_LIMIT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_adc_sample    (in_adc_sample),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_temp_now     (out_temp_now),
    .out_heater_on    (out_heater_on),
    .out_temp_highest (out_temp_highest),
    .out_temp_lowest  (out_temp_lowest),
    .out_publish_now  (out_publish_now),
    .out_zero_reading (out_zero_reading)
  );

endmodule

/* verif/tb_thermistor_thermostat.sv */
module tb_thermistor_thermostat;

  localparam int PUB_LIMIT = 20;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic signed [12:0] temp;
    logic heat;
    logic signed [12:0] hi;
    logic signed [12:0] lo;
    logic pub;
    logic zero;
  } reading_t;

  class temp_scoreboard;
    int set_point;
    longint coef_a, coef_b, coef_c;
    bit heat_flag;
    int hi_seen, lo_seen, pub_count;
    reading_t pending[$];
    int errors, samples, results;

    function new();
      set_point = 320;
      coef_a = 1241510000;
      coef_b = 257420000;
      coef_c = 96397;
      heat_flag = 0;
      hi_seen = -4096;
      lo_seen = 4095;
      pub_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        thermo_pkg::CFG_SET_TEMP: set_point = int'($signed(d[12:0]));
        thermo_pkg::CFG_COEFF_A: coef_a = longint'($signed(d));
        thermo_pkg::CFG_COEFF_B: coef_b = longint'($signed(d));
        default: coef_c = longint'($signed(d));
      endcase
    endfunction

    // thermistor resistance in Q32.16, then natural log in Q.24
    function longint unsigned ln_resistance(logic [11:0] smp);
      longint unsigned r, m, frac, lg2;
      int p;
      if (smp == 0) r = (64'd1 << 48) - 1;
      else begin
        r = ((64'd10000 * (64'd33 * 4095 - 64'd24 * smp)) << 16) / (64'd24 * smp);
        if (r > (64'd1 << 48) - 1) r = (64'd1 << 48) - 1;
      end
      if (r < (64'd1 << 16)) r = 64'd1 << 16;
      p = 0;
      for (int i = 0; i < 64; i++) if (r[i]) p = i;
      m = (p >= 31) ? (r >> (p - 31)) : (r << (31 - p));
      frac = 0;
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      lg2 = (longint'(p - 16) << 24) + frac;
      return (lg2 * 64'd2977044472) >> 32;
    endfunction

    function void note_sample(logic [11:0] smp);
      longint unsigned ln, sq, cu;
      longint s, num, den, t;
      reading_t e;
      ln = ln_resistance(smp);
      sq = (ln * ln) >> 24;
      cu = (sq * ln) >> 24;
      s = coef_a + ((coef_b * longint'(ln)) >>> 24) + coef_c * longint'(cu >> 24)
          + ((coef_c * longint'(cu & 64'hFFFFFF)) >>> 24);
      if (s == 0) t = 4095;
      else begin
        num = 64'sd10 * (64'sd1 <<< 44) - 64'sd43691 * s;
        den = 64'sd10 * s;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        t = (num >= 0) ? num / den : -(((-num) + den - 1) / den);
      end
      if (t > 4095) t = 4095;
      if (t < -4096) t = -4096;
      if (t > set_point + 16) heat_flag = 0;
      else if (t < set_point - 16) heat_flag = 1;
      if (t > hi_seen) hi_seen = int'(t);
      if (t < lo_seen) lo_seen = int'(t);
      e.pub = 0;
      if (pub_count > PUB_LIMIT) begin
        e.pub = 1;
        pub_count = 0;
      end else pub_count++;
      e.temp = t[12:0];
      e.heat = heat_flag;
      e.hi = hi_seen[12:0];
      e.lo = lo_seen[12:0];
      e.zero = (smp == 0);
      pending.push_back(e);
      samples++;
    endfunction

    function void check_result(reading_t a);
      reading_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result temp=%0d", $time, a.temp);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.temp !== e.temp) begin
        $display("%0t: temp_now exp %0d got %0d", $time, e.temp, a.temp);
        errors++;
      end
      if (a.heat !== e.heat) begin
        $display("%0t: heater_on exp %0d got %0d", $time, e.heat, a.heat);
        errors++;
      end
      if (a.hi !== e.hi) begin
        $display("%0t: temp_highest exp %0d got %0d", $time, e.hi, a.hi);
        errors++;
      end
      if (a.lo !== e.lo) begin
        $display("%0t: temp_lowest exp %0d got %0d", $time, e.lo, a.lo);
        errors++;
      end
      if (a.pub !== e.pub) begin
        $display("%0t: publish_now exp %0d got %0d", $time, e.pub, a.pub);
        errors++;
      end
      if (a.zero !== e.zero) begin
        $display("%0t: zero_reading exp %0d got %0d", $time, e.zero, a.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [11:0] in_adc_sample = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [12:0] out_temp_now, out_temp_highest, out_temp_lowest;
  logic out_heater_on, out_publish_now, out_zero_reading;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = thermo_pkg::CFG_SET_TEMP;
  logic [31:0] cfg_data = 0;

  temp_scoreboard sb = new();
  bit idling = 1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int cfg_writes = 0;

  always #6 clk = ~clk;

  thermistor_thermostat DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_adc_sample(in_adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temp_now(out_temp_now), .out_heater_on(out_heater_on),
    .out_temp_highest(out_temp_highest), .out_temp_lowest(out_temp_lowest),
    .out_publish_now(out_publish_now), .out_zero_reading(out_zero_reading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // transaction monitors and watchdog
  always @(posedge clk) begin
    reading_t a;
    bit busy;
    busy = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_adc_sample);
        busy = 1;
      end
      if (out_valid && !out_stall) begin
        a.temp = out_temp_now;
        a.heat = out_heater_on;
        a.hi = out_temp_highest;
        a.lo = out_temp_lowest;
        a.pub = out_publish_now;
        a.zero = out_zero_reading;
        sb.check_result(a);
        busy = 1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
        busy = 1;
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  task automatic send_sample(logic [11:0] smp);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    in_adc_sample <= smp;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic program_regs(logic signed [12:0] st, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c);
    drain();
    write_reg(thermo_pkg::CFG_SET_TEMP, {{19{st[12]}}, st});
    write_reg(thermo_pkg::CFG_COEFF_A, a);
    write_reg(thermo_pkg::CFG_COEFF_B, b);
    write_reg(thermo_pkg::CFG_COEFF_C, c);
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 12'($urandom_range(0, 3));
      1: return 12'($urandom_range(4090, 4095));
      2: return 12'($urandom_range(1000, 3000));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_samples(int n);
    repeat (n) send_sample(pick_sample());
  endtask

  initial begin
    logic [11:0] directed[$] = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd4094, 12'd2048,
                                 12'd2047, 12'hAAA, 12'h555, 12'd0, 12'd3500, 12'd3000,
                                 12'd2600, 12'd2200, 12'd1800, 12'd1500, 12'd1200,
                                 12'd800, 12'd400, 12'd100, 12'd3800, 12'd4000};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_sample(directed[i]);
    random_samples(70);
    program_regs(13'sd400, 32'd1241510000, 32'd257420000, 32'd96397);
    random_samples(50);
    program_regs(-13'sd4096, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    random_samples(30);
    program_regs(13'sd4095, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    random_samples(30);
    // zero denominator
    program_regs(13'sd0, 32'd0, 32'd0, 32'd0);
    random_samples(15);
    program_regs(-13'sd200, -32'sd1241510000, -32'sd257420000, -32'sd96397);
    random_samples(30);
    program_regs(13'($urandom), $urandom, $urandom, $urandom);
    random_samples(30);
    program_regs(13'sd350, 32'd1241510000 + $urandom_range(0, 20000000),
                 32'd257420000 - $urandom_range(0, 5000000), $urandom_range(0, 200000));
    random_samples(50);
    idling = 0;
    program_regs(13'sd320, 32'd1241510000, 32'd257420000, 32'd96397);
    random_samples(80);
    drain();
    $display("covered %0d samples and %0d results over %0d register writes",
             sb.samples, sb.results, cfg_writes);
    $display("settings included extreme set points, extreme and zero coefficients");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* thermistor_thermostat.f */
src/thermo_pkg.sv
src/thermo_ctrl.sv
src/thermo_dpath.sv
src/thermistor_thermostat.sv
verif/tb_thermistor_thermostat.sv
